[design/cwk_pkg.sv]
package cwk_pkg;

    localparam int MAX_TARGET = 255;
    localparam int MAX_LENGTH = 65536;
    localparam int RING_DEPTH = MAX_TARGET + 1;

    localparam int POS_W   = 17;
    localparam int FILL_W  = 9;
    localparam int IDX_W   = 8;
    localparam int CFG_W   = 8;
    localparam int TOTAL_W = 32;
    localparam int PROD_W  = 2 * POS_W;
    localparam int SUM_W   = PROD_W + 1;

    localparam logic [POS_W-1:0]   MAX_INDEX = POS_W'(MAX_LENGTH);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic              clear;
        logic              shift;
        logic              write;
        logic [IDX_W-1:0]  wr_idx;
        logic [POS_W-1:0]  pos;
    } t_cell_ctrl;

    typedef struct packed {
        logic              valid;
        logic              last_op;
        logic [POS_W-1:0]  gap_after;
        logic [POS_W-1:0]  gap_before;
    } t_mac_op;

endpackage

[design/count_windows_with_k_odd.sv]
// Exactly-k-odd window counter.
// Input channel: one word per element (i_value, i_last), valid/ready handshake.
// Only bit 0 of i_value matters. i_last marks the final element of a sequence.
// Output channel: one word per sequence (o_window_count), valid/ready handshake,
// the number of contiguous windows holding exactly odd_target odd elements,
// saturating at 0xFFFFFFFF.
// Configuration: i_cfg_we writes i_cfg_data into odd_target (0 acts as 1);
// write it only between words.
// Throughput: one word per cycle unless an output stall holds the pipeline;
// after each last word the input is held off for the end-of-sequence step.
// Result path: after the last word is accepted, the result goes through the
// cell row step, the multiply stage and accumulation into the output register.
// The odd positions sit in a row of cells that shifts by one on each pop,
// so the oldest two are always at the first two cells.
// Reset: clears the sequence state and the pending result, odd_target = 1.
// Receiver stall: a finished result waits in the output register while input
// keeps flowing; the pipeline only stops when the next result is ready to
// be stored and the previous one has not been taken.
module count_windows_with_k_odd
    import cwk_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [POS_W-1:0]    i_value,
    input  logic                i_last,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [TOTAL_W-1:0]  o_window_count
);

    logic [CFG_W-1:0]   r_target;
    logic [FILL_W-1:0]  r_fill;
    logic [POS_W-1:0]   r_newest;
    logic [POS_W-1:0]   r_index;
    logic               r_sent;

    logic [CFG_W-1:0]   w_target;
    logic               w_stall;
    logic               w_en;
    logic               w_acc;
    logic               w_fire;
    logic               w_op;
    logic               w_pop;
    logic [POS_W-1:0]   w_pos;
    logic [FILL_W-1:0]  w_fill_m1;
    t_cell_ctrl         w_ctrl;
    t_mac_op            w_mac_op;
    logic [POS_W-1:0]   w_cell [RING_DEPTH];

    assign w_target  = (r_target == '0) ? CFG_W'(1) : r_target;
    assign w_en      = !w_stall;
    assign o_in_ready = w_en && !r_sent;
    assign w_acc     = i_in_valid && o_in_ready;
    assign w_fire    = r_sent && w_en;
    assign w_op      = (w_acc && i_value[0]) || w_fire;
    assign w_pos     = r_index + POS_W'(1);
    assign w_pop     = w_op && (r_fill > {1'b0, w_target});
    assign w_fill_m1 = r_fill - FILL_W'(1);

    assign w_ctrl.clear  = !i_rst_n || w_fire;
    assign w_ctrl.shift  = w_pop;
    assign w_ctrl.write  = w_op;
    assign w_ctrl.wr_idx = w_pop ? w_fill_m1[IDX_W-1:0] : r_fill[IDX_W-1:0];
    assign w_ctrl.pos    = w_pos;

    genvar gi;
    generate
        for (gi = 0; gi < RING_DEPTH; gi++) begin : g_cell
            logic [POS_W-1:0] w_right;
            if (gi == RING_DEPTH - 1) begin : g_end
                assign w_right = '0;
            end else begin : g_mid
                assign w_right = w_cell[gi+1];
            end
            cwk_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_index (IDX_W'(gi)),
                .i_right (w_right),
                .o_pos   (w_cell[gi])
            );
        end
    endgenerate

    assign w_mac_op.valid      = w_op && (w_pop || w_fire);
    assign w_mac_op.last_op    = w_fire;
    assign w_mac_op.gap_after  = w_pop ? (w_pos - r_newest) : '0;
    assign w_mac_op.gap_before = w_pop ? (w_cell[1] - w_cell[0]) : '0;

    cwk_mac u_mac (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_op           (w_mac_op),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_window_count (o_window_count),
        .o_stall        (w_stall)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= CFG_W'(1);
            r_fill   <= FILL_W'(1);
            r_newest <= '0;
            r_index  <= '0;
            r_sent   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end
            if (w_fire) begin
                r_fill   <= FILL_W'(1);
                r_newest <= '0;
                r_index  <= '0;
                r_sent   <= 1'b0;
            end else begin
                if (w_op) begin
                    r_newest <= w_pos;
                    if (!w_pop) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                end
                if (w_acc) begin
                    if (r_index < MAX_INDEX) begin
                        r_index <= r_index + POS_W'(1);
                    end
                    if (i_last) begin
                        r_sent <= 1'b1;
                    end
                end
            end
        end
    end

    // last word schedules the end-of-sequence step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_last) |=> r_sent)
        else $error("end step not scheduled");

    // end-of-sequence step leaves a fresh ring holding only the seed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (!r_sent && r_fill == FILL_W'(1) && r_index == '0))
        else $error("sequence state not cleared");

    // ring fill stays within the cell row
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != '0) && (r_fill <= FILL_W'(RING_DEPTH)))
        else $error("ring fill out of range");

endmodule

[design/cwk_cell.sv]
module cwk_cell
    import cwk_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [IDX_W-1:0]  i_index,
    input  logic [POS_W-1:0]  i_right,
    output logic [POS_W-1:0]  o_pos
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;

    always_comb begin
        n_pos = r_pos;
        if (i_ctrl.clear) begin
            if (i_index == '0) begin
                n_pos = '0;
            end
        end else if (i_ctrl.write && (i_index == i_ctrl.wr_idx)) begin
            n_pos = i_ctrl.pos;
        end else if (i_ctrl.shift) begin
            n_pos = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
    end

    assign o_pos = r_pos;

endmodule

[design/cwk_mac.sv]
module cwk_mac
    import cwk_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_mac_op             i_op,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [TOTAL_W-1:0]  o_window_count,
    output logic                o_stall
);

    logic                r_s1_valid;
    logic                r_s1_last;
    logic [POS_W-1:0]    r_s1_a;
    logic [POS_W-1:0]    r_s1_b;
    logic                r_s2_valid;
    logic                r_s2_last;
    logic [PROD_W-1:0]   r_prod;
    logic [TOTAL_W-1:0]  r_total;
    logic                r_out_valid;
    logic [TOTAL_W-1:0]  r_count;

    logic [SUM_W-1:0]    w_sum;
    logic [TOTAL_W-1:0]  w_sat;

    assign w_sum = {{(SUM_W-TOTAL_W){1'b0}}, r_total} + {1'b0, r_prod};
    assign w_sat = (w_sum[SUM_W-1:TOTAL_W] != '0) ? TOTAL_MAX : w_sum[TOTAL_W-1:0];
    assign o_stall = r_s2_valid && r_s2_last && r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_last   <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s2_last   <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_en) begin
                r_s1_valid <= i_op.valid;
                r_s1_last  <= i_op.last_op;
                r_s2_valid <= r_s1_valid;
                r_s2_last  <= r_s1_last;
                if (r_s2_valid) begin
                    if (r_s2_last) begin
                        r_total     <= '0;
                        r_out_valid <= 1'b1;
                    end else begin
                        r_total <= w_sat;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_a <= i_op.gap_after;
            r_s1_b <= i_op.gap_before;
            r_prod <= PROD_W'(r_s1_a) * PROD_W'(r_s1_b);
            if (r_s2_valid && r_s2_last) begin
                r_count <= w_sat;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_window_count = r_count;

    // a held result is only replaced once it has been taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_count))
        else $error("result overwritten while held");

    // nothing accumulates while the pipeline is held
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_total))
        else $error("total moved during stall");

    // a stall lasts only while the output is blocked
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && r_s2_last))
        else $error("stall without held result");

endmodule

[bench/tb_count_windows_with_k_odd.sv]
`timescale 1ns / 100ps

module tb_count_windows_with_k_odd;
    import cwk_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_WORDS   = 1560;
    localparam int PROBE_ROWS     = 29;

    typedef struct packed {
        logic               is_cfg;
        logic [CFG_W-1:0]   cfg;
        logic [POS_W-1:0]   value;
        logic               is_end;
        logic               typed;
        logic [TOTAL_W-1:0] count;
    } t_probe_row;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data  = '0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [POS_W-1:0]   i_value     = '0;
    logic               i_last      = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [TOTAL_W-1:0] o_window_count;

    // predictor state
    logic [POS_W-1:0]   odd_ring [RING_DEPTH];
    int unsigned        ring_start;
    int unsigned        ring_count;
    logic [POS_W-1:0]   elem_pos;
    logic [TOTAL_W-1:0] tally;
    logic [CFG_W-1:0]   target_reg;

    logic [TOTAL_W-1:0] count_due [$];
    int                 fault_count  = 0;
    int                 words_sent   = 0;
    int                 results_seen = 0;
    int                 idle_cycles  = 0;
    int                 stall_left   = 0;
    bit                 steady       = 1'b0;

    // directed words: after reset, extremes, target zero, mid-sequence change, full target
    t_probe_row probe_rows [PROBE_ROWS] = '{
        '{1'b0, 8'd0,   17'h00000, 1'b1, 1'b1, 32'd0},
        '{1'b0, 8'd0,   17'h00001, 1'b1, 1'b1, 32'd1},
        '{1'b0, 8'd0,   17'h1FFFF, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h10000, 1'b1, 1'b1, 32'd2},
        '{1'b1, 8'd0,   17'h00000, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h00003, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h0ABCD, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h15555, 1'b1, 1'b1, 32'd3},
        '{1'b1, 8'd3,   17'h00000, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h00001, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h1FFFE, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h0F0F3, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h0AAAA, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h00005, 1'b1, 1'b0, 32'd0},
        '{1'b1, 8'd4,   17'h00000, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h00001, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h12345, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h0FFFF, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h10001, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h00007, 1'b0, 1'b0, 32'd0},
        '{1'b1, 8'd2,   17'h00000, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h00009, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h0FFFE, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h1000B, 1'b1, 1'b0, 32'd0},
        '{1'b1, 8'd255, 17'h00000, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h00001, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h00000, 1'b0, 1'b0, 32'd0},
        '{1'b0, 8'd0,   17'h1FFFF, 1'b1, 1'b1, 32'd0},
        '{1'b1, 8'd1,   17'h00000, 1'b0, 1'b0, 32'd0}
    };

    count_windows_with_k_odd u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_window_count (o_window_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [CFG_W-1:0] pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return CFG_W'($urandom_range(1, 4));
        if (r < 60) return '0;
        if (r < 80) return CFG_W'($urandom_range(5, 16));
        if (r < 92) return CFG_W'($urandom_range(17, 64));
        if (r < 97) return CFG_W'(MAX_TARGET);
        return CFG_W'($urandom_range(65, 254));
    endfunction

    task automatic clear_run();
        ring_start  = 0;
        ring_count  = 1;
        odd_ring[0] = '0;
        elem_pos    = '0;
        tally       = '0;
    endtask

    // pos is the element position plus one, so the seed sits at zero
    task automatic take_odd_pos(input logic [POS_W-1:0] pos);
        int unsigned       lim;
        logic [POS_W-1:0]  dropped;
        logic [POS_W-1:0]  oldest;
        logic [POS_W-1:0]  newest;
        longint unsigned   gap_after;
        longint unsigned   gap_before;
        longint unsigned   sum;
        lim = (target_reg == '0) ? 1 : int'(target_reg);
        if (lim > MAX_TARGET) lim = MAX_TARGET;
        if (ring_count >= lim + 1) begin
            dropped    = odd_ring[ring_start];
            ring_start = (ring_start + 1) % RING_DEPTH;
            ring_count--;
            oldest     = odd_ring[ring_start];
            newest     = odd_ring[(ring_start + ring_count - 1) % RING_DEPTH];
            gap_after  = 64'(pos) - 64'(newest);
            gap_before = 64'(oldest) - 64'(dropped);
            sum        = 64'(tally) + gap_after * gap_before;
            tally      = (sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        end
        if (ring_count < RING_DEPTH) begin
            odd_ring[(ring_start + ring_count) % RING_DEPTH] = pos;
            ring_count++;
        end
    endtask

    task automatic absorb_word(input logic [POS_W-1:0] v, input logic is_end,
                               output bit done, output logic [TOTAL_W-1:0] total);
        done  = 1'b0;
        total = '0;
        if (v[0]) take_odd_pos(elem_pos + 1'b1);
        if (elem_pos < MAX_INDEX) elem_pos++;
        if (is_end) begin
            take_odd_pos(elem_pos + 1'b1);
            total = tally;
            done  = 1'b1;
            clear_run();
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [TOTAL_W-1:0] got,
                                 input logic [TOTAL_W-1:0] want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        fault_count++;
    endtask

    task automatic push_word(input logic [POS_W-1:0] v, input logic is_end,
                             input logic typed, input logic [TOTAL_W-1:0] typed_count);
        int                 hold;
        bit                 done;
        logic [TOTAL_W-1:0] total;
        hold = pick_gap();
        if (hold > 0) begin
            i_in_valid <= 1'b0;
            repeat (hold) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_last     <= is_end;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        words_sent++;
        absorb_word(v, is_end, done, total);
        if (done) count_due = {count_due, (typed ? typed_count : total)};
    endtask

    task automatic set_target(input logic [CFG_W-1:0] t);
        i_in_valid <= 1'b0;
        while (count_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= t;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        target_reg = t;
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        logic [TOTAL_W-1:0] want;
        if (o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            results_seen++;
            if (count_due.size() == 0) begin
                flag_mismatch("unexpected window_count", o_window_count, '0);
            end else begin
                want = count_due.pop_front();
                if (o_window_count !== want) flag_mismatch("window_count", o_window_count, want);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
            (o_out_valid === 1'b1 && i_out_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int               rand_words;
        int               run_len;
        int               density;
        int               split;
        int unsigned      eff;
        logic [POS_W-1:0] v;
        target_reg = 8'd1;
        clear_run();
        rand_words = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_rows[r]) begin
            if (probe_rows[r].is_cfg) begin
                set_target(probe_rows[r].cfg);
            end else begin
                push_word(probe_rows[r].value, probe_rows[r].is_end,
                          probe_rows[r].typed, probe_rows[r].count);
            end
        end

        while (rand_words < RANDOM_WORDS) begin
            steady = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 2) == 0) set_target(pick_target());
            eff = (target_reg == '0) ? 1 : int'(target_reg);
            density = $urandom_range(0, 100);
            if (eff > 16 && $urandom_range(0, 1) == 0) begin
                run_len = eff + $urandom_range(0, 20);
                density = 90;
            end else if ($urandom_range(0, 9) == 0) begin
                run_len = $urandom_range(25, 300);
            end else begin
                run_len = $urandom_range(1, 24);
            end
            split = 0;
            if (run_len > 1 && $urandom_range(0, 19) == 0) split = $urandom_range(1, run_len - 1);
            for (int k = 0; k < run_len; k++) begin
                if (split != 0 && k == split) set_target(pick_target());
                v = POS_W'($urandom);
                v[0] = ($urandom_range(1, 100) <= density);
                push_word(v, k == run_len - 1, 1'b0, '0);
                rand_words++;
            end
        end

        i_in_valid <= 1'b0;
        while (count_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d window counts over %0d words, targets from zero to full ring",
                 results_seen, words_sent);
        $display("runs included target changes inside a sequence and back to back words");
        if (fault_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
design/cwk_pkg.sv
design/cwk_cell.sv
design/cwk_mac.sv
design/count_windows_with_k_odd.sv
bench/tb_count_windows_with_k_odd.sv
